// ===== hdl/drlx_pkg.sv =====
// Shared types, codes and constants of the run-level expander with DC prediction.
package drlx_pkg;

   localparam int BLOCK_COEFFS = 64;
   localparam int POS_W = $clog2(BLOCK_COEFFS + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] OP_SLICE_START = 3'd0;
   localparam logic [2:0] OP_MB_START    = 3'd1;
   localparam logic [2:0] OP_INTRA_DC    = 3'd2;
   localparam logic [2:0] OP_RUN_LEVEL   = 3'd3;
   localparam logic [2:0] OP_END_BLOCK   = 3'd4;

   typedef struct packed {
      logic [2:0]  operation;
      logic [1:0]  component;
      logic [3:0]  dc_size;
      logic [10:0] dc_bits;
      logic [5:0]  run;
      logic [11:0] level_bits;
      logic        escape;
      logic        sign;
      logic        intra;
      logic        skipped_before;
   } req_type;

   typedef struct packed {
      logic [5:0]         position;
      logic signed [15:0] value;
      logic               block_end;
      logic               overflow;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_DC,
      CMD_RUN,
      CMD_EOB
   } cmd_kind_type;

   // Work handed from the front to the back.
   typedef struct packed {
      cmd_kind_type kind;
      logic [5:0]   run;
      logic [15:0]  value;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [15:0] pred_reset_value(input logic [1:0] precision);
      logic [15:0] v;
      unique case (precision)
         2'd0: v = 16'd128;
         2'd1: v = 16'd256;
         2'd2: v = 16'd512;
         default: v = 16'd1024;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/drlx_front.sv =====
// Front end: token decode, DC prediction and level formation.
module drlx_front
   import drlx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  logic        accept,
   input  req_type     req,
   output logic        push,
   output cmd_type     cmd
);

   logic [1:0]  precision_ff;
   logic [15:0] pred_ff [3];

   logic [1:0]  comp_idx;
   logic [10:0] size_mask;
   logic [10:0] masked;
   logic [15:0] half;
   logic [16:0] span;
   logic [15:0] diff;
   logic [15:0] dc_sum;
   logic [15:0] level;
   logic        pred_clear;

   always_comb begin
      comp_idx = (req.component > 2'd2) ? 2'd2 : req.component;
      size_mask = (req.dc_size >= 4'd11) ? 11'h7FF
                                         : 11'((16'd1 << req.dc_size) - 16'd1);
      masked = req.dc_bits & size_mask;
      half = 16'd1 << (req.dc_size - 4'd1);
      span = 17'd1 << req.dc_size;
      // Values below half encode negative differentials.
      if (req.dc_size == 4'd0) begin
         diff = 16'd0;
      end else if ({5'd0, masked} >= half) begin
         diff = {5'd0, masked};
      end else begin
         diff = 16'({6'd0, masked} + 17'd1 - span);
      end
      dc_sum = pred_ff[comp_idx] + diff;

      if (req.escape) begin
         level = {{4{req.level_bits[11]}}, req.level_bits};
      end else if (req.sign) begin
         level = 16'd0 - {4'd0, req.level_bits};
      end else begin
         level = {4'd0, req.level_bits};
      end

      pred_clear = accept && ((req.operation == OP_SLICE_START) ||
                   ((req.operation == OP_MB_START) &&
                    (!req.intra || req.skipped_before)));

      push = accept && ((req.operation == OP_INTRA_DC) ||
                        (req.operation == OP_RUN_LEVEL) ||
                        (req.operation == OP_END_BLOCK));
      cmd.run = req.run;
      if (req.operation == OP_INTRA_DC) begin
         cmd.kind = CMD_DC;
         cmd.value = dc_sum;
      end else if (req.operation == OP_RUN_LEVEL) begin
         cmd.kind = CMD_RUN;
         cmd.value = level;
      end else begin
         cmd.kind = CMD_EOB;
         cmd.value = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         precision_ff <= 2'd0;
         for (int i = 0; i < 3; i++) begin
            pred_ff[i] <= pred_reset_value(2'd0);
         end
      end else begin
         if (csr_wr_en) begin
            precision_ff <= csr_wr_data;
         end
         if (pred_clear) begin
            for (int i = 0; i < 3; i++) begin
               pred_ff[i] <= pred_reset_value(precision_ff);
            end
         end else if (accept && (req.operation == OP_INTRA_DC)) begin
            pred_ff[comp_idx] <= dc_sum;
         end
      end
   end

endmodule

// ===== hdl/drlx_queue.sv =====
// Short command queue between the front and back ends.
module drlx_queue
   import drlx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type status
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;

   assign head_cmd = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hdl/drlx_back.sv =====
// Back end: expands queued commands into coefficient beats in scan order.
module drlx_back
   import drlx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type head_cmd,
   input  logic    head_valid,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [POS_W-1:0] position_ff, position_in;
   logic             active_ff, active_in;
   logic [5:0]       remain_ff, remain_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             advance;
   logic             full_block;
   logic             at_end;
   logic [5:0]       remain;

   always_comb begin
      advance = head_valid && (!rsp_valid_ff || rsp_ready);
      full_block = (position_ff >= POS_W'(BLOCK_COEFFS));
      at_end = (position_ff == POS_W'(BLOCK_COEFFS - 1));
      remain = active_ff ? remain_ff : head_cmd.run;

      position_in = position_ff;
      active_in = active_ff;
      remain_in = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      pop = 1'b0;

      if (advance) begin
         rsp_in.position = 6'(position_ff);
         rsp_in.value = '0;
         rsp_in.block_end = at_end;
         rsp_in.overflow = 1'b0;
         rsp_in.last = 1'b0;
         unique case (head_cmd.kind)
            CMD_DC: begin
               rsp_valid_in = 1'b1;
               rsp_in.position = 6'd0;
               rsp_in.value = head_cmd.value;
               rsp_in.block_end = 1'b0;
               rsp_in.last = 1'b1;
               position_in = POS_W'(1);
               pop = 1'b1;
            end
            CMD_RUN: begin
               rsp_valid_in = 1'b1;
               if (full_block) begin
                  // Nothing fits: a lone overflow marker at position zero.
                  rsp_in.position = 6'd0;
                  rsp_in.block_end = 1'b0;
                  rsp_in.overflow = 1'b1;
                  rsp_in.last = 1'b1;
                  pop = 1'b1;
               end else begin
                  if (remain == 6'd0) begin
                     rsp_in.value = head_cmd.value;
                  end
                  rsp_in.overflow = (remain != 6'd0) && at_end;
                  rsp_in.last = (remain == 6'd0) || at_end;
                  position_in = position_ff + 1'b1;
                  if (rsp_in.last) begin
                     pop = 1'b1;
                     active_in = 1'b0;
                  end else begin
                     active_in = 1'b1;
                     remain_in = remain - 6'd1;
                  end
               end
            end
            default: begin
               pop = 1'b1;
               position_in = '0;
               if (!full_block) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.last = at_end;
                  if (!at_end) begin
                     pop = 1'b0;
                     position_in = position_ff + 1'b1;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         position_ff <= position_in;
         active_ff <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      remain_ff <= remain_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== hdl/dct_run_level_expander_dc_pred.sv =====
// Tokens are queued, then the back end registers one coefficient beat per cycle
// while rsp_ready allows: a DC token gives one beat, a run-level token run plus
// one, an end of block the remaining positions. Start tokens are taken one per
// cycle while the queue has room and produce no beat; a four-entry queue lets
// the front keep accepting while the back expands. Synchronous reset empties the
// queue, rewinds the position, and sets precision 0 and predictors 128.
module dct_run_level_expander_dc_pred
   import drlx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   queue_status_type q_status;
   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          head_cmd;

   assign req_ready = !q_status.full;

   drlx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (req_valid && req_ready),
      .req         (req_data),
      .push        (push),
      .cmd         (push_cmd)
   );

   drlx_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   drlx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .head_valid (!q_status.empty),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== tb/tb_dct_run_level_expander_dc_pred.sv =====
// Self-checking testbench for the run-level expander with DC prediction.
`timescale 1ns / 1ps

import drlx_pkg::*;

class coeff_scoreboard;
   logic [1:0]  precision;
   logic [15:0] dc_pred [3];
   int unsigned next_pos;
   rsp_type     coeffs_due [$];
   int unsigned errors;
   int unsigned coeffs_checked;
   int unsigned tokens_seen;
   int unsigned overflow_beats;
   int unsigned block_ends;

   function new();
      precision = 2'd0;
      next_pos = 0;
      errors = 0;
      coeffs_checked = 0;
      tokens_seen = 0;
      overflow_beats = 0;
      block_ends = 0;
      reset_dc_pred();
   endfunction

   function void reset_dc_pred();
      logic [15:0] base;
      base = 16'd128 << precision;
      dc_pred[0] = base;
      dc_pred[1] = base;
      dc_pred[2] = base;
   endfunction

   function void set_precision(input logic [1:0] p);
      precision = p;
   endfunction

   function void append_beat(input rsp_type c);
      coeffs_due.insert(coeffs_due.size(), c);
   endfunction

   function void push_coeff(input int unsigned pos, input logic [15:0] val);
      rsp_type c;
      c.position = 6'(pos);
      c.value = val;
      c.block_end = (pos == BLOCK_COEFFS - 1);
      c.overflow = 1'b0;
      c.last = 1'b0;
      append_beat(c);
   endfunction

   // Works out every coefficient beat that one accepted token causes.
   function void expand_token(input req_type t);
      int unsigned count;
      int unsigned m;
      int          diff;
      int          half;
      logic [1:0]  comp;
      logic [10:0] bits;
      logic [15:0] sum;
      logic [15:0] level;
      bit          ran_out;
      rsp_type     tail;
      count = 0;
      ran_out = 1'b0;
      tokens_seen++;
      case (t.operation)
         OP_SLICE_START: reset_dc_pred();
         OP_MB_START: begin
            if (!t.intra || t.skipped_before) reset_dc_pred();
         end
         OP_INTRA_DC: begin
            // The selector saturates, so component three shares the Cr predictor.
            comp = (t.component > 2'd2) ? 2'd2 : t.component;
            bits = t.dc_bits;
            diff = 0;
            if (t.dc_size != 4'd0) begin
               half = 1 << (t.dc_size - 1);
               if (t.dc_size < 4'd11) bits = bits & 11'((1 << t.dc_size) - 1);
               if (int'(bits) >= half) diff = int'(bits);
               else diff = int'(bits) + 1 - 2 * half;
            end
            sum = 16'(int'(dc_pred[comp]) + diff);
            dc_pred[comp] = sum;
            push_coeff(0, sum);
            count = 1;
            next_pos = 1;
         end
         OP_RUN_LEVEL: begin
            if (t.escape) level = {{4{t.level_bits[11]}}, t.level_bits};
            else if (t.sign) level = 16'(-int'(t.level_bits));
            else level = {4'd0, t.level_bits};
            for (m = 0; m <= t.run; m++) begin
               if (next_pos >= BLOCK_COEFFS) begin
                  ran_out = 1'b1;
                  break;
               end
               push_coeff(next_pos, (m == t.run) ? level : 16'd0);
               count++;
               next_pos++;
            end
            if (ran_out) begin
               // A token that finds the block full still leaves a marker beat.
               if (count == 0) begin
                  push_coeff(0, 16'd0);
                  count = 1;
               end
               tail = coeffs_due.pop_back();
               tail.overflow = 1'b1;
               append_beat(tail);
            end
         end
         OP_END_BLOCK: begin
            while (next_pos < BLOCK_COEFFS) begin
               push_coeff(next_pos, 16'd0);
               count++;
               next_pos++;
            end
            next_pos = 0;
         end
         default: ;
      endcase
      if (count != 0) begin
         tail = coeffs_due.pop_back();
         tail.last = 1'b1;
         append_beat(tail);
      end
   endfunction

   task report(input string msg);
      errors++;
      $display("MISMATCH: %s", msg);
   endtask

   task check_coeff(input rsp_type got);
      rsp_type want;
      coeffs_checked++;
      if (coeffs_due.size() == 0) begin
         report($sformatf("beat at position %0d with nothing due", got.position));
      end else begin
         want = coeffs_due.pop_front();
         if (want.overflow) overflow_beats++;
         if (want.block_end) block_ends++;
         if (got.position !== want.position)
            report($sformatf("position: got %0d, expected %0d", got.position, want.position));
         if (got.value !== want.value)
            report($sformatf("value at %0d: got %0d, expected %0d",
                             want.position, got.value, want.value));
         if (got.block_end !== want.block_end)
            report($sformatf("block_end at %0d: got %0b, expected %0b",
                             want.position, got.block_end, want.block_end));
         if (got.overflow !== want.overflow)
            report($sformatf("overflow at %0d: got %0b, expected %0b",
                             want.position, got.overflow, want.overflow));
         if (got.last !== want.last)
            report($sformatf("last at %0d: got %0b, expected %0b",
                             want.position, got.last, want.last));
      end
   endtask
endclass

module tb_dct_run_level_expander_dc_pred;

   localparam int TOKENS_PER_PHASE = 125;
   localparam int LONG_HOLD = 400;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT = 2000000;
   localparam logic [2:0] OP_UNUSED_LO = OP_END_BLOCK + 3'd1;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_HALF,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_wr_en = 1'b0;
   logic [1:0] csr_wr_data = 2'd0;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   coeff_scoreboard sb;
   int unsigned cycle_count = 0;
   int unsigned hold_requests = 0;
   int unsigned burst_left = 0;
   int unsigned tokens_sent = 0;

   dct_run_level_expander_dc_pred dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d beats still due", cycle_count,
                  sb.coeffs_due.size());
         $display("** dct_run_level_expander_dc_pred: FAILED **");
         $finish;
      end
   end

   // Both handshakes are sampled here, before this edge's updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.expand_token(req_data);
         if (rsp_valid && rsp_ready) sb.check_coeff(rsp_data);
      end
   end

   initial begin : rsp_side
      stall_mode_type mode;
      int unsigned mode_left;
      int unsigned hold_left;
      int unsigned holds_served;
      int unsigned tick;
      mode = STALL_NONE;
      mode_left = 0;
      hold_left = 0;
      holds_served = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 160);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               STALL_NONE:  rsp_ready <= 1'b1;
               STALL_HALF:  rsp_ready <= 1'($urandom_range(0, 1));
               STALL_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:     rsp_ready <= (tick % 3 != 0);
            endcase
         end
      end
   end

   function automatic req_type token_of(input logic [2:0] op);
      logic [63:0] raw;
      req_type t;
      raw = {$urandom(), $urandom()};
      t = req_type'(raw[$bits(req_type)-1:0]);
      t.operation = op;
      return t;
   endfunction

   function automatic req_type noise_token();
      return token_of(3'($urandom_range(0, 7)));
   endfunction

   function automatic req_type dc_token(input logic [1:0] comp, input logic [3:0] size,
                                        input logic [10:0] bits);
      req_type t;
      t = token_of(OP_INTRA_DC);
      t.component = comp;
      t.dc_size = size;
      t.dc_bits = bits;
      return t;
   endfunction

   function automatic req_type rl_token(input logic [5:0] run, input logic [11:0] lbits,
                                        input logic esc, input logic sgn);
      req_type t;
      t = token_of(OP_RUN_LEVEL);
      t.run = run;
      t.level_bits = lbits;
      t.escape = esc;
      t.sign = sgn;
      return t;
   endfunction

   function automatic req_type mb_token(input logic intra, input logic skipped);
      req_type t;
      t = token_of(OP_MB_START);
      t.intra = intra;
      t.skipped_before = skipped;
      return t;
   endfunction

   // The sender offers tokens in bursts; valid only drops between bursts.
   task automatic send_token(input req_type t);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (t.operation <= OP_END_BLOCK) tokens_sent++;
   endtask

   // Start tokens leave no beat behind, so a wait of SETTLE_CYCLES lets them clear the pipe.
   // The first edge lets the monitor note the token accepted at the last one.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.coeffs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_precision(input logic [1:0] p);
      csr_wr_en <= 1'b1;
      csr_wr_data <= p;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_precision(p);
   endtask

   task automatic run_directed();
      send_token(token_of(OP_SLICE_START));
      send_token(dc_token(2'd0, 4'd0, 11'h7FF));
      // Most negative differential drives the Cb sum below zero.
      send_token(dc_token(2'd1, 4'd11, 11'h000));
      send_token(dc_token(2'd2, 4'd11, 11'h7FF));
      send_token(dc_token(2'd3, 4'd15, 11'h400));
      send_token(dc_token(2'd0, 4'd3, 11'h7FB));
      send_token(rl_token(6'd0, 12'hFFF, 1'b0, 1'b0));
      send_token(rl_token(6'd5, 12'hFFF, 1'b0, 1'b1));
      send_token(rl_token(6'd0, 12'h800, 1'b1, 1'b0));
      send_token(rl_token(6'd2, 12'h7FF, 1'b1, 1'b1));
      // A DC token mid-block restarts the block at position one.
      send_token(dc_token(2'd1, 4'd1, 11'h000));
      send_token(rl_token(6'd63, 12'h001, 1'b0, 1'b0));
      send_token(rl_token(6'd0, 12'h000, 1'b0, 1'b0));
      send_token(token_of(OP_END_BLOCK));
      send_token(rl_token(6'd63, 12'h123, 1'b0, 1'b0));
      send_token(token_of(OP_END_BLOCK));
      send_token(rl_token(6'd3, 12'h000, 1'b1, 1'b0));
      send_token(token_of(OP_END_BLOCK));
      send_token(mb_token(1'b1, 1'b0));
      send_token(dc_token(2'd0, 4'd2, 11'h003));
      send_token(mb_token(1'b0, 1'b0));
      send_token(dc_token(2'd0, 4'd2, 11'h000));
      send_token(mb_token(1'b1, 1'b1));
      send_token(dc_token(2'd1, 4'd0, 11'h000));
      for (int i = 0; i < 3; i++) send_token(token_of(OP_UNUSED_LO + 3'(i)));
      send_token(token_of(OP_END_BLOCK));
   endtask

   task automatic send_block(input bit intra, input int unsigned idx);
      logic [1:0] comp;
      logic [3:0] size;
      int unsigned coeffs;
      logic [11:0] lbits;
      bit esc;
      if (intra) begin
         comp = (idx < 4) ? 2'd0 : ((idx == 4) ? 2'd1 : 2'd2);
         if ($urandom_range(0, 19) == 0) comp = 2'($urandom_range(0, 3));
         size = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(12, 15))
                                           : 4'($urandom_range(0, 11));
         send_token(dc_token(comp, size, 11'($urandom_range(0, 2047))));
      end
      coeffs = $urandom_range(0, 5);
      for (int unsigned c = 0; c < coeffs; c++) begin
         esc = ($urandom_range(0, 4) == 0);
         if (esc || $urandom_range(0, 3) == 0) lbits = 12'($urandom_range(0, 4095));
         else lbits = 12'($urandom_range(1, 15));
         send_token(rl_token(($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                          : 6'($urandom_range(0, 7)),
                             lbits, esc, 1'($urandom_range(0, 1))));
      end
      // Now and then a block is left without its end token.
      if ($urandom_range(0, 19) != 0) send_token(token_of(OP_END_BLOCK));
   endtask

   task automatic send_slice();
      int unsigned mbs;
      int unsigned blocks;
      bit intra;
      if ($urandom_range(0, 9) != 0) send_token(token_of(OP_SLICE_START));
      mbs = $urandom_range(1, 3);
      for (int unsigned m = 0; m < mbs; m++) begin
         intra = ($urandom_range(0, 2) != 0);
         send_token(mb_token(intra, ($urandom_range(0, 3) == 0)));
         blocks = $urandom_range(1, 6);
         for (int unsigned b = 0; b < blocks; b++) send_block(intra, b);
      end
   endtask

   task automatic run_random_phase(input int unsigned quota, input bit drain_midway);
      int unsigned first;
      first = tokens_sent;
      while (tokens_sent - first < quota) begin
         if (drain_midway && tokens_sent - first >= quota / 2) begin
            drain_midway = 1'b0;
            pause_until_drained();
         end
         if ($urandom_range(0, 9) == 0) send_token(noise_token());
         else send_slice();
      end
   endtask

   initial begin : stimulus
      logic [1:0] settings [4];
      settings = '{2'd3, 2'd1, 2'd2, 2'd0};
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      pause_until_drained();
      foreach (settings[i]) begin
         write_precision(settings[i]);
         // The second phase starts with the receiver holding off for a long stretch.
         if (i == 1) hold_requests++;
         run_random_phase(TOKENS_PER_PHASE, (i == 0));
         pause_until_drained();
      end
      $display("Run covered %0d tokens and %0d coefficient beats over DC precisions 0 to 3.",
               sb.tokens_seen, sb.coeffs_checked);
      $display("It saw %0d block ends and %0d overflow beats; %0d mismatches.",
               sb.block_ends, sb.overflow_beats, sb.errors);
      if (sb.errors == 0) $display("** dct_run_level_expander_dc_pred: PASSED **");
      else $display("** dct_run_level_expander_dc_pred: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/drlx_pkg.sv
hdl/drlx_front.sv
hdl/drlx_queue.sv
hdl/drlx_back.sv
hdl/dct_run_level_expander_dc_pred.sv
tb/tb_dct_run_level_expander_dc_pred.sv
